FILE: hdl/chr_pkg.sv
package chr_pkg;

  // Field widths of the command and response words.
  localparam int OPCODE_W     = 1;
  localparam int CHAR_W       = 8;
  localparam int RECENCY_W    = 4;
  localparam int POSITION_W   = 6;
  localparam int LINE_COUNT_W = 5;
  localparam int STATUS_W     = 2;

  // Default ring geometry.
  localparam int DEF_HISTORY_DEPTH = 16;
  localparam int DEF_LINE_BYTES    = 64;

  // Command opcodes.
  localparam logic [OPCODE_W-1:0] OP_PUSH = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_READ = 1'b1;

  // Push status codes.
  localparam logic [STATUS_W-1:0] ST_NONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_STORED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUP    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic finish;
    logic copy_step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic commit;
    logic copy_done;
  } sts_t;

endpackage

FILE: hdl/chr_if.sv
interface chr_cmd_if import chr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [OPCODE_W-1:0]   opcode;
  logic [CHAR_W-1:0]     char_code;
  logic [RECENCY_W-1:0]  recency_index;
  logic [POSITION_W-1:0] char_position;

  modport source (output valid, opcode, char_code, recency_index, char_position,
                  input ready);
  modport sink   (input valid, opcode, char_code, recency_index, char_position,
                  output ready);
endinterface

interface chr_rsp_if import chr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CHAR_W-1:0]       read_char;
  logic                    read_valid;
  logic [LINE_COUNT_W-1:0] line_count;
  logic [STATUS_W-1:0]     push_status;

  modport source (output valid, read_char, read_valid, line_count, push_status,
                  input ready);
  modport sink   (input valid, read_char, read_valid, line_count, push_status,
                  output ready);
endinterface

FILE: hdl/chr_ctrl.sv
module chr_ctrl import chr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_COPY = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_free;

  // The output register can take a new word when empty or being drained.
  assign out_free = !out_valid || out_ready;

  // Next state and datapath commands.
  always_comb begin
    ctl        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        ctl.accept = in_valid;
        if (in_valid) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (out_free) begin
          ctl.finish = 1'b1;
          state_next = sts.commit ? S_COPY : S_IDLE;
        end
      end
      S_COPY: begin
        ctl.copy_step = 1'b1;
        if (sts.copy_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output word valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: hdl/chr_datapath.sv
module chr_datapath import chr_pkg::*; #(
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
  parameter int LINE_BYTES    = DEF_LINE_BYTES
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    ctl,
  output sts_t                    sts,
  input  logic [OPCODE_W-1:0]     in_opcode,
  input  logic [CHAR_W-1:0]       in_char,
  input  logic [RECENCY_W-1:0]    in_recency,
  input  logic [POSITION_W-1:0]   in_position,
  output logic [CHAR_W-1:0]       read_char,
  output logic                    read_valid,
  output logic [LINE_COUNT_W-1:0] line_count,
  output logic [STATUS_W-1:0]     push_status
);

  localparam int SW   = $clog2(HISTORY_DEPTH);
  localparam int PW   = $clog2(LINE_BYTES);
  localparam int HW   = $clog2(HISTORY_DEPTH + 1);
  localparam int XW   = ((SW > RECENCY_W) ? SW : RECENCY_W) + 1;
  localparam int QW   = (PW > POSITION_W) ? PW : POSITION_W;
  localparam int CMPW = (HW > RECENCY_W) ? HW : RECENCY_W;

  // Ring memories.
  logic [CHAR_W-1:0] line_store [HISTORY_DEPTH][LINE_BYTES];
  logic [CHAR_W-1:0] staging_chars [LINE_BYTES];
  logic [PW-1:0]     line_lengths [HISTORY_DEPTH];

  // Ring and staging control state.
  logic [SW-1:0] write_slot;
  logic [HW-1:0] held_lines;
  logic [PW-1:0] staging_length;
  logic          differs_flag;
  logic          overlength_flag;

  // Registered item and lookup results.
  logic [OPCODE_W-1:0]   item_op;
  logic [CHAR_W-1:0]     item_char;
  logic [POSITION_W-1:0] item_pos;
  logic [SW-1:0]         look_slot;
  logic                  look_valid;
  logic [CHAR_W-1:0]     store_rdata;

  // Copy sequencer.
  logic [SW-1:0]     copy_slot;
  logic [PW-1:0]     copy_len;
  logic [PW-1:0]     copy_cnt;
  logic [PW-1:0]     pend_pos;
  logic              pend;
  logic [CHAR_W-1:0] stg_rdata;

  logic [SW-1:0] newest;
  logic [XW-1:0] idx_x, newest_x, slot_x;
  logic          hit;
  logic [SW-1:0] rd_slot;
  logic [PW-1:0] rd_pos;

  logic [PW-1:0] cur_len;
  logic          is_push, is_term, room, char_differs, dup, empty_cmd, commit;
  logic [STATUS_W-1:0] status;
  logic [HW-1:0] held_next;
  logic [CHAR_W-1:0] rchar;

  // Lookup address for the incoming word: the newest line for a push, the
  // requested line for a read.
  always_comb begin
    newest   = (write_slot == '0) ? SW'(HISTORY_DEPTH - 1) : write_slot - 1'b1;
    idx_x    = XW'(in_recency);
    newest_x = XW'(newest);
    slot_x   = (idx_x <= newest_x) ? newest_x - idx_x
                                   : newest_x + XW'(HISTORY_DEPTH) - idx_x;
    hit      = CMPW'(in_recency) < CMPW'(held_lines);
    rd_slot  = (in_opcode == OP_READ && hit) ? slot_x[SW-1:0] : newest;
    rd_pos   = (in_opcode == OP_READ) ? PW'(in_position) : staging_length;
  end

  // Evaluation of the registered item against the lookup result.
  always_comb begin
    cur_len      = line_lengths[look_slot];
    is_push      = (item_op == OP_PUSH);
    is_term      = (item_char == '0);
    room         = staging_length < PW'(LINE_BYTES - 1);
    char_differs = (held_lines == '0) || (staging_length >= cur_len) ||
                   (store_rdata != item_char);
    dup          = (held_lines != '0) && !differs_flag && !overlength_flag &&
                   (staging_length == cur_len);
    empty_cmd    = (staging_length == '0) && !overlength_flag;
    commit       = is_push && is_term && !empty_cmd && !dup;

    if (!is_push || !is_term) begin
      status = ST_NONE;
    end else if (empty_cmd) begin
      status = ST_EMPTY;
    end else if (dup) begin
      status = ST_DUP;
    end else begin
      status = ST_STORED;
    end

    held_next = (commit && held_lines != HW'(HISTORY_DEPTH)) ? held_lines + 1'b1
                                                             : held_lines;

    if (!is_push && look_valid && (QW'(item_pos) < QW'(cur_len))) begin
      rchar = store_rdata;
    end else begin
      rchar = '0;
    end
  end

  assign sts.commit    = commit;
  assign sts.copy_done = (copy_cnt == copy_len) && !pend;

  // Control state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot      <= '0;
      held_lines      <= '0;
      staging_length  <= '0;
      differs_flag    <= 1'b0;
      overlength_flag <= 1'b0;
      pend            <= 1'b0;
      copy_cnt        <= '0;
    end else begin
      if (ctl.finish && is_push) begin
        if (!is_term) begin
          if (room) begin
            staging_length <= staging_length + 1'b1;
            differs_flag   <= differs_flag | char_differs;
          end else begin
            overlength_flag <= 1'b1;
          end
        end else begin
          staging_length  <= '0;
          differs_flag    <= 1'b0;
          overlength_flag <= 1'b0;
          if (commit) begin
            write_slot <= (write_slot == SW'(HISTORY_DEPTH - 1)) ? '0
                                                                 : write_slot + 1'b1;
            held_lines <= held_next;
          end
        end
      end

      pend <= ctl.copy_step && (copy_cnt < copy_len);
      if (ctl.finish && commit) begin
        copy_cnt <= '0;
      end else if (ctl.copy_step && (copy_cnt < copy_len)) begin
        copy_cnt <= copy_cnt + 1'b1;
      end
    end
  end

  // Item capture and copy bookkeeping.
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      item_op    <= in_opcode;
      item_char  <= in_char;
      item_pos   <= in_position;
      look_slot  <= rd_slot;
      look_valid <= hit;
    end
    if (ctl.finish && commit) begin
      line_lengths[write_slot] <= staging_length;
      copy_slot                <= write_slot;
      copy_len                 <= staging_length;
    end
    if (ctl.copy_step && (copy_cnt < copy_len)) begin
      pend_pos <= copy_cnt;
    end
  end

  // Line store: read at acceptance, written by the copy sequencer.
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      store_rdata <= line_store[rd_slot][rd_pos];
    end
    if (pend) begin
      line_store[copy_slot][pend_pos] <= stg_rdata;
    end
  end

  // Staging buffer: written per pushed character, read during the copy.
  always_ff @(posedge clk) begin
    if (ctl.finish && is_push && !is_term && room) begin
      staging_chars[staging_length] <= item_char;
    end
    if (ctl.copy_step && (copy_cnt < copy_len)) begin
      stg_rdata <= staging_chars[copy_cnt];
    end
  end

  // Response word register.
  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      read_char   <= rchar;
      read_valid  <= !is_push && look_valid;
      line_count  <= LINE_COUNT_W'(held_next);
      push_status <= status;
    end
  end

endmodule

FILE: hdl/command_history_ring_core.sv
// Command history ring.
// The cmd channel carries one word per push character or read request. A push
// word (opcode 0) appends char_code to the staged command; a zero character
// ends it, and the command is then stored, dropped as a duplicate of the
// newest line, or ignored when empty. A read word (opcode 1) returns one
// character of the line at recency_index (0 is the newest) and char_position.
// The rsp channel returns exactly one word per cmd word, in order.
// The cmd word and its line store read are registered at acceptance, and
// the response word register is loaded from them once it is free; the next
// cmd word is not accepted until then. A stored command then runs a copy
// from the staging buffer into the ring, one character per cycle, which
// holds cmd.ready low until the copy is done.
// Reset empties the ring and clears the staged command; no clearing pass is
// needed because entries are never read before they are written.
// When the receiver stalls, the response word is held in its register; one
// more cmd word is accepted and waits until that register frees up.
module command_history_ring_core import chr_pkg::*; #(
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
  parameter int LINE_BYTES    = DEF_LINE_BYTES
) (
  input logic        clk,
  input logic        rst,
  chr_cmd_if.sink    cmd,
  chr_rsp_if.source  rsp
);

  cmd_t ctl;
  sts_t sts;

  // Sequencing of words and of the commit copy.
  chr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // Ring storage, staging and comparison.
  chr_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .LINE_BYTES    (LINE_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .in_opcode   (cmd.opcode),
    .in_char     (cmd.char_code),
    .in_recency  (cmd.recency_index),
    .in_position (cmd.char_position),
    .read_char   (rsp.read_char),
    .read_valid  (rsp.read_valid),
    .line_count  (rsp.line_count),
    .push_status (rsp.push_status)
  );

  // One word at a time: cmd.ready is low in the cycle after an accepted word.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> !cmd.ready)
    else $error("cmd accepted on consecutive cycles");

  // A read never reports a push outcome.
  a_read_no_status: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.read_valid |-> rsp.push_status == ST_NONE)
    else $error("read word carries a push status");

  // A nonzero character only comes from a valid read.
  a_char_needs_valid: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.read_char != '0 |-> rsp.read_valid)
    else $error("character returned without a valid read");

  // The held line count never exceeds the ring depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> int'(rsp.line_count) <= HISTORY_DEPTH)
    else $error("line count beyond ring depth");

endmodule

FILE: tb/tb_top.sv
module tb_top import chr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = DEF_HISTORY_DEPTH;
  localparam int LINE         = DEF_LINE_BYTES;
  localparam int RANDOM_WORDS = 80;
  localparam int HOLD_CYCLES  = 200;
  localparam int TAIL_CYCLES  = 12;
  localparam int CYCLE_LIMIT  = 300000;

  typedef logic [CHAR_W-1:0] text_t[$];

  typedef struct packed {
    logic [CHAR_W-1:0]       read_char;
    logic                    read_valid;
    logic [LINE_COUNT_W-1:0] line_count;
    logic [STATUS_W-1:0]     push_status;
  } rsp_word_t;

  logic clk;
  logic rst;

  chr_cmd_if cmd_if ();
  chr_rsp_if rsp_if ();

  command_history_ring_core DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .rsp (rsp_if)
  );

  // Mirror of the ring, the staged command and its comparison flags.
  logic [CHAR_W-1:0] ring_chars [DEPTH][LINE];
  int                ring_len   [DEPTH];
  int                wr_slot;
  int                held;
  logic [CHAR_W-1:0] stage_chars [LINE];
  int                stage_len;
  bit                stage_differs;
  bit                stage_overlong;

  rsp_word_t responses_due[$];
  int        mismatch_count;
  int        words_sent;
  int        cycle_count;
  int        cmd_idle_pct;
  int        rsp_idle_pct;
  logic      hold_request;
  int        hold_left;

  // Applies one command word to the mirror and returns the response it must produce.
  function automatic rsp_word_t advance_history(logic [OPCODE_W-1:0] op,
                                                logic [CHAR_W-1:0] ch,
                                                logic [RECENCY_W-1:0] idx,
                                                logic [POSITION_W-1:0] pos);
    rsp_word_t r;
    int        newest;
    int        slot;
    r      = '0;
    newest = (wr_slot + DEPTH - 1) % DEPTH;
    if (op == OP_PUSH) begin
      r.push_status = ST_NONE;
      if (ch != 0) begin
        // Stage the character while comparing it with the newest line.
        if (stage_len < LINE - 1) begin
          if (held == 0 || stage_len >= ring_len[newest] ||
              ring_chars[newest][stage_len] != ch) begin
            stage_differs = 1'b1;
          end
          stage_chars[stage_len] = ch;
          stage_len++;
        end else begin
          stage_overlong = 1'b1;
        end
      end else begin
        // The terminator decides between empty, duplicate and stored.
        if (stage_len == 0 && !stage_overlong) begin
          r.push_status = ST_EMPTY;
        end else if (held > 0 && !stage_differs && !stage_overlong &&
                     stage_len == ring_len[newest]) begin
          r.push_status = ST_DUP;
        end else begin
          for (int i = 0; i < stage_len; i++) ring_chars[wr_slot][i] = stage_chars[i];
          ring_len[wr_slot] = stage_len;
          wr_slot = (wr_slot + 1) % DEPTH;
          if (held < DEPTH) held++;
          r.push_status = ST_STORED;
        end
        stage_len      = 0;
        stage_differs  = 1'b0;
        stage_overlong = 1'b0;
      end
    end else if (idx < held) begin
      slot = (wr_slot + DEPTH - 1 - idx) % DEPTH;
      r.read_valid = 1'b1;
      if (pos < ring_len[slot]) r.read_char = ring_chars[slot][pos];
    end
    r.line_count = LINE_COUNT_W'(held);
    return r;
  endfunction

  // Returns the newest committed line, or an empty text when the ring is empty.
  function automatic text_t newest_line();
    text_t t;
    int    slot;
    if (held > 0) begin
      slot = (wr_slot + DEPTH - 1) % DEPTH;
      for (int i = 0; i < ring_len[slot]; i++) t.push_back(ring_chars[slot][i]);
    end
    return t;
  endfunction

  function automatic text_t random_text(int len);
    text_t t;
    for (int i = 0; i < len; i++) t.push_back(CHAR_W'($urandom_range(1, 255)));
    return t;
  endfunction

  // Sends one command word and records the response it must produce.
  task automatic send_word(logic [OPCODE_W-1:0] op, logic [CHAR_W-1:0] ch,
                           logic [RECENCY_W-1:0] idx, logic [POSITION_W-1:0] pos);
    int gap;
    gap = 0;
    while ($urandom_range(99) < cmd_idle_pct) gap++;
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid         <= 1'b1;
    cmd_if.opcode        <= op;
    cmd_if.char_code     <= ch;
    cmd_if.recency_index <= idx;
    cmd_if.char_position <= pos;
    do @(posedge clk); while (!(cmd_if.valid && cmd_if.ready));
    responses_due.push_back(advance_history(op, ch, idx, pos));
    words_sent++;
  endtask

  // Push words carry random read fields so that the block must ignore them.
  task automatic push_char(logic [CHAR_W-1:0] ch);
    send_word(OP_PUSH, ch, RECENCY_W'($urandom), POSITION_W'($urandom));
  endtask

  task automatic read_at(int idx, int pos);
    send_word(OP_READ, CHAR_W'($urandom), RECENCY_W'(idx), POSITION_W'(pos));
  endtask

  // Reads mostly held lines within or just past their ends, sometimes any index and position.
  task automatic random_read();
    int idx;
    int pos;
    int slot;
    idx = $urandom_range(0, 15);
    pos = $urandom_range(0, 63);
    if (held > 0 && $urandom_range(3) != 0) begin
      idx  = $urandom_range(0, held - 1);
      slot = (wr_slot + DEPTH - 1 - idx) % DEPTH;
      if ($urandom_range(3) != 0) pos = $urandom_range(0, ring_len[slot] + 1);
    end
    read_at(idx, pos);
  endtask

  // Pushes a whole command and its terminator, with reads mixed in at random.
  task automatic push_command(text_t text, int read_pct);
    foreach (text[i]) begin
      if ($urandom_range(99) < read_pct) random_read();
      push_char(text[i]);
    end
    push_char('0);
  endtask

  task automatic test_empty_ring();
    read_at(0, 0);
    read_at(15, 63);
    push_char('0);
  endtask

  task automatic test_store_and_read();
    push_command('{8'hFF, 8'h01, 8'h80, 8'h7F, 8'h55, 8'hAA}, 0);
    read_at(0, 0);
    read_at(0, 5);
    read_at(0, 6);
    read_at(0, 63);
    read_at(1, 0);
  endtask

  task automatic test_duplicate_rules();
    push_command('{8'hFF, 8'h01, 8'h80, 8'h7F, 8'h55, 8'hAA}, 0);
    push_command('{8'hFF, 8'h01}, 0);
    push_command('{8'hFF, 8'h01}, 0);
    push_command('{8'hFF, 8'h01, 8'h80}, 0);
    push_command('{8'hFF, 8'h01, 8'h81}, 0);
  endtask

  // Reads between staged characters see only committed lines.
  task automatic test_read_during_staging();
    push_char(8'h6C);
    read_at(0, 0);
    push_char(8'h73);
    read_at(1, 1);
    read_at(0, 2);
    push_char('0);
    read_at(0, 1);
  endtask

  // A full-length line can be a duplicate; an over-length one never is.
  task automatic test_overlength_command();
    text_t t;
    t = random_text(LINE - 1);
    push_command(t, 0);
    push_command(t, 0);
    t = random_text(LINE + 6);
    push_command(t, 0);
    push_command(t, 0);
    read_at(0, LINE - 2);
    read_at(0, LINE - 1);
    read_at(1, LINE - 2);
  endtask

  // Wraps the ring so that the oldest lines are overwritten.
  task automatic test_ring_wrap();
    for (int i = 0; i < DEPTH + 2; i++) push_command(random_text($urandom_range(1, 3)), 0);
    read_at(DEPTH - 1, 0);
    read_at(0, 0);
  endtask

  // The receiver holds off while the sender keeps offering words.
  task automatic test_response_backpressure();
    cmd_idle_pct = 0;
    hold_request <= 1'b1;
    push_command(random_text(4), 0);
    for (int i = 0; i < 8; i++) random_read();
    cmd_idle_pct = 31;
  endtask

  // Mostly well-formed commands: new, repeated, edited or long; reads in between.
  task automatic test_random_traffic();
    int    start;
    int    kind;
    int    k;
    text_t t;
    start = words_sent;
    while (words_sent - start < RANDOM_WORDS) begin
      if (words_sent - start >= 10 && words_sent - start < 70) begin
        cmd_idle_pct = 0;
        rsp_idle_pct = 0;
      end else begin
        cmd_idle_pct = 31;
        rsp_idle_pct = 31;
      end
      kind = $urandom_range(99);
      if (kind < 45) begin
        push_command(random_text($urandom_range(0, 8)), 10);
      end else if (kind < 60) begin
        push_command(newest_line(), 10);
      end else if (kind < 72) begin
        t = newest_line();
        case ($urandom_range(2))
          0: if (t.size() > 1) void'(t.pop_back());
          1: t.push_back(CHAR_W'($urandom_range(1, 255)));
          default: begin
            if (t.size() > 0) begin
              k    = $urandom_range(0, t.size() - 1);
              t[k] = t[k] ^ CHAR_W'($urandom_range(1, 255));
              if (t[k] == 0) t[k] = 8'h01;
            end
          end
        endcase
        push_command(t, 10);
      end else if (kind < 75) begin
        push_command(random_text($urandom_range(LINE - 4, LINE + 6)), 2);
      end else begin
        repeat ($urandom_range(1, 4)) random_read();
      end
    end
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog on the total run length.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles, %0d words outstanding", cycle_count,
                 responses_due.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Response ready, with random stalls and an occasional long hold-off.
  initial begin
    rsp_if.ready <= 1'b0;
    hold_request <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request <= 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
    end
  end

  // Each accepted response word is compared with the oldest one due.
  always @(posedge clk) begin
    rsp_word_t got;
    rsp_word_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got.read_char   = rsp_if.read_char;
      got.read_valid  = rsp_if.read_valid;
      got.line_count  = rsp_if.line_count;
      got.push_status = rsp_if.push_status;
      if (responses_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: response word with none due: char=%02h valid=%0d count=%0d status=%0d",
                   $realtime, got.read_char, got.read_valid, got.line_count,
                   got.push_status);
      end else begin
        want = responses_due.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mismatch exp char=%02h valid=%0d count=%0d status=%0d, got char=%02h valid=%0d count=%0d status=%0d",
                     $realtime, want.read_char, want.read_valid, want.line_count,
                     want.push_status, got.read_char, got.read_valid, got.line_count,
                     got.push_status);
        end
      end
    end
  end

  // Test sequence.
  initial begin
    mismatch_count = 0;
    words_sent     = 0;
    wr_slot        = 0;
    held           = 0;
    stage_len      = 0;
    stage_differs  = 1'b0;
    stage_overlong = 1'b0;
    cmd_idle_pct   = 31;
    rsp_idle_pct   = 31;
    rst                  <= 1'b1;
    cmd_if.valid         <= 1'b0;
    cmd_if.opcode        <= OP_PUSH;
    cmd_if.char_code     <= '0;
    cmd_if.recency_index <= '0;
    cmd_if.char_position <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_empty_ring();
    test_store_and_read();
    test_duplicate_rules();
    test_read_during_staging();
    test_overlength_command();
    test_ring_wrap();
    test_response_backpressure();
    test_random_traffic();

    // Drain the remaining response words, then watch for stray ones.
    cmd_if.valid <= 1'b0;
    while (responses_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
